FILE: rtl/ail_pkg.sv
// Shared codes for the indexed list unit: request actions and status values.
// No dependencies.
package ail_pkg;

  // Request action codes; code 7 is a no-op
  typedef enum logic [2:0] {
    ACT_APPEND     = 3'd0,
    ACT_INSERT     = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_READ       = 3'd3,
    ACT_WRITE      = 3'd4,
    ACT_FIND_FIRST = 3'd5,
    ACT_FIND_LAST  = 3'd6
  } act_t;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

FILE: rtl/indexed_list_insert_remove_search_unit.sv
// Indexed list unit: request decoder and shift/search sequencer around the list memory.
// Depends on ail_pkg and ail_ram.
//
// Usage:
//   A request (action, position, value) is taken on a rising edge where start
//   is high and busy is low. Exactly one result comes back per request, shown
//   for one cycle with done high: read_value, found, found_position, status,
//   and entry_total (the list length after the request).
//   Requests that finish straight from idle: append, write, no-op, any
//   rejected request, insert at the end of the list, remove of the last
//   entry, and find first / find last in an empty list. A read waits for
//   the registered read data of the list memory. An insert at p < n moves
//   entries up from the tail down to p, then writes the new value at p. A
//   remove at p moves entries down from p + 1 to the tail. A search steps
//   from one end until a hit or the far end. Shifts and searches visit one
//   entry per cycle, as the list memory has a single read port.
//   A new request may be taken in the same cycle as done is high.
//   Reset empties the list (count to zero); the memory is not cleared, since
//   only entries below the count are ever read.
//   The receiver cannot stall: each result is valid for its done cycle only.
module indexed_list_insert_remove_search_unit #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [4:0]  position,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] read_value,
  output logic        found,
  output logic [3:0]  found_position,
  output logic [4:0]  entry_total,
  output logic [1:0]  status
);

  import ail_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REM_SHIFT,
    S_SEARCH
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic [IDX_W-1:0]         pos_idx;
  logic [ELEMENT_WIDTH-1:0] val_r;
  logic                     up;

  // Memory port signals
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  // Result staging
  logic        fin;
  logic [1:0]  fin_status;
  logic [31:0] fin_rv;
  logic        fin_found;
  logic [3:0]  fin_fpos;

  // Derived values
  logic [63:0]              val_wide;
  logic [63:0]              rd_wide;
  logic [ELEMENT_WIDTH-1:0] val_in;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [IDX_W-1:0]         pos_in;
  logic [IDX_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         cnt_idx;
  logic                     full;
  logic                     hit;

  assign val_wide = 64'(value);
  assign val_in   = val_wide[ELEMENT_WIDTH-1:0];
  assign rd_wide  = 64'(mem_rdata);
  assign pos_ext  = PW'(position);
  assign cnt_ext  = PW'(count);
  assign pos_in   = IDX_W'(position);
  assign cnt_m1   = IDX_W'(count - CNT_W'(1));
  assign cnt_idx  = IDX_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign hit      = (mem_rdata == val_r);

  assign busy        = (state != S_IDLE);
  assign entry_total = 5'(count);

  ail_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next-state, memory control and result selection
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = mem_rdata;
    mem_raddr  = idx;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_rv     = '0;
    fin_found  = 1'b0;
    fin_fpos   = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_idx;
                mem_wdata  = val_in;
                count_next = count + CNT_W'(1);
              end
            end
            ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else if (pos_ext == cnt_ext) begin
                fin        = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = pos_in;
                mem_wdata  = val_in;
                count_next = count + CNT_W'(1);
              end else begin
                // open a gap: move entries up from the tail
                mem_raddr  = cnt_m1;
                idx_next   = cnt_m1;
                state_next = S_INS_SHIFT;
              end
            end
            ACT_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end else if (pos_in == cnt_m1) begin
                fin        = 1'b1;
                count_next = count - CNT_W'(1);
              end else begin
                // close the gap: move entries down from pos+1
                mem_raddr  = pos_in + IDX_W'(1);
                idx_next   = pos_in + IDX_W'(1);
                state_next = S_REM_SHIFT;
              end
            end
            ACT_READ: begin
              if (pos_ext >= cnt_ext) begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end else begin
                mem_raddr  = pos_in;
                state_next = S_READ;
              end
            end
            ACT_WRITE: begin
              fin = 1'b1;
              if (pos_ext >= cnt_ext) begin
                fin_status = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_in;
                mem_wdata = val_in;
              end
            end
            ACT_FIND_FIRST: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_SEARCH;
              end
            end
            ACT_FIND_LAST: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                mem_raddr  = cnt_m1;
                idx_next   = cnt_m1;
                state_next = S_SEARCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        fin        = 1'b1;
        fin_rv     = rd_wide[31:0];
        state_next = S_IDLE;
      end

      // entry idx arrives; it moves to idx+1
      S_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx + IDX_W'(1);
        mem_wdata = mem_rdata;
        if (idx == pos_idx) begin
          state_next = S_INS_PUT;
        end else begin
          mem_raddr = idx - IDX_W'(1);
          idx_next  = idx - IDX_W'(1);
        end
      end

      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_idx;
        mem_wdata  = val_r;
        count_next = count + CNT_W'(1);
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      // entry idx arrives; it moves to idx-1
      S_REM_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx - IDX_W'(1);
        mem_wdata = mem_rdata;
        if (idx == cnt_m1) begin
          count_next = count - CNT_W'(1);
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_raddr = idx + IDX_W'(1);
          idx_next  = idx + IDX_W'(1);
        end
      end

      // compare entry idx, step toward the far end of the list
      S_SEARCH: begin
        if (hit) begin
          fin        = 1'b1;
          fin_found  = 1'b1;
          fin_fpos   = 4'(idx);
          state_next = S_IDLE;
        end else if ((up && idx == cnt_m1) || (!up && idx == '0)) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else if (up) begin
          mem_raddr = idx + IDX_W'(1);
          idx_next  = idx + IDX_W'(1);
        end else begin
          mem_raddr = idx - IDX_W'(1);
          idx_next  = idx - IDX_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, count, request latches and registered results
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == S_IDLE && start) begin
      pos_idx <= pos_in;
      val_r   <= val_in;
      up      <= (action != ACT_FIND_LAST);
    end
    if (fin) begin
      read_value     <= fin_rv;
      found          <= fin_found;
      found_position <= fin_fpos;
      status         <= fin_status;
    end
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
  end

endmodule

FILE: rtl/ail_ram.sv
// List element storage: one write port, one read port, registered read data.
// No dependencies.
module ail_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/indexed_list_insert_remove_search_unit_tb.sv
// Self-checking testbench for the indexed list unit: directed corner requests, then biased random
// traffic checked against a shadow list model kept in a small scoreboard class.
// Depends on ail_pkg and the indexed_list_insert_remove_search_unit RTL.
`timescale 1ns / 1ps

module indexed_list_insert_remove_search_unit_tb;

  import ail_pkg::*;

  localparam int LIST_DEPTH = 16;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    logic [3:0]  found_position;
    logic [4:0]  entry_total;
    logic [1:0]  status;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the unit
  class list_shadow;
    logic [31:0]  entries [LIST_DEPTH];
    int           count;
    int           errors;
    list_result_t expected_results[$];

    function new();
      count  = 0;
      errors = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    // Apply one accepted request to the shadow list and queue its result
    function void predict_request(logic [2:0] act, logic [4:0] pos, logic [31:0] val);
      list_result_t r;
      int i;
      r = '0;
      case (act)
        ACT_APPEND: begin
          if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            entries[count] = val;
            count++;
          end
        end
        ACT_INSERT: begin
          // position is checked before fullness
          if (pos > count) begin
            r.status = ST_RANGE;
          end else if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            count++;
          end
        end
        ACT_REMOVE: begin
          if (pos >= count) begin
            r.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        ACT_READ: begin
          if (pos >= count) r.status = ST_RANGE;
          else r.read_value = entries[pos];
        end
        ACT_WRITE: begin
          if (pos >= count) r.status = ST_RANGE;
          else entries[pos] = val;
        end
        ACT_FIND_FIRST: begin
          for (i = 0; i < count; i++) begin
            if (!r.found && entries[i] == val) begin
              r.found          = 1'b1;
              r.found_position = i[3:0];
            end
          end
        end
        ACT_FIND_LAST: begin
          for (i = count - 1; i >= 0; i--) begin
            if (!r.found && entries[i] == val) begin
              r.found          = 1'b1;
              r.found_position = i[3:0];
            end
          end
        end
        default: ;  // unused code: no-op
      endcase
      r.entry_total = count[4:0];
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Compare one strobed result against the oldest outstanding request
    function void check_result(list_result_t got);
      list_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        compare_field("read_value", exp_r.read_value, got.read_value);
        compare_field("found", 32'(exp_r.found), 32'(got.found));
        compare_field("found_position", 32'(exp_r.found_position), 32'(got.found_position));
        compare_field("entry_total", 32'(exp_r.entry_total), 32'(got.entry_total));
        compare_field("status", 32'(exp_r.status), 32'(got.status));
      end
    endfunction
  endclass

  localparam logic [2:0] ACT_NOP = 3'd7;
  localparam int ITEM_COUNT     = 1800;
  localparam int PHASE_LEN      = 150;
  localparam int CALM_TAIL      = 200;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 2 * LIST_DEPTH + 4;

  localparam int MIX_GROW    = 0;
  localparam int MIX_SHRINK  = 1;
  localparam int MIX_BALANCE = 2;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [4:0]  position;
  logic [31:0] value;
  logic        done;
  logic [31:0] read_value;
  logic        found;
  logic [3:0]  found_position;
  logic [4:0]  entry_total;
  logic [1:0]  status;

  list_shadow sb;
  int         stall_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  indexed_list_insert_remove_search_unit #(
    .CAPACITY      (LIST_DEPTH),
    .ELEMENT_WIDTH (32)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .position       (position),
    .value          (value),
    .done           (done),
    .read_value     (read_value),
    .found          (found),
    .found_position (found_position),
    .entry_total    (entry_total),
    .status         (status)
  );

  // Result checker and no-progress watchdog
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_result({read_value, found, found_position, entry_total, status});
    end
    if (rst || done === 1'b1 || (start && !busy)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Present one request and hold it until the unit takes it
  task automatic send_request(input logic [2:0] act, input logic [4:0] pos,
                              input logic [31:0] val);
    start    <= 1'b1;
    action   <= act;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.predict_request(act, pos, val);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Values: often a stored entry (search hits, duplicates), often a corner value
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && sb.count > 0) return sb.entries[$urandom_range(0, sb.count - 1)];
    if (roll < 7) begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h0000_0001;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  // Positions: mostly in range for the current count, sometimes anywhere
  function automatic logic [4:0] pick_position(input bit allow_end);
    if ($urandom_range(0, 9) == 0 || sb.count == 0) return 5'($urandom_range(0, LIST_DEPTH));
    if (allow_end) return 5'($urandom_range(0, sb.count));
    return 5'($urandom_range(0, sb.count - 1));
  endfunction

  task automatic random_request(input int mix);
    int unsigned roll;
    int          grow_pct;
    int          shrink_pct;
    logic [2:0]  act;
    roll       = $urandom_range(0, 99);
    grow_pct   = (mix == MIX_GROW) ? 55 : (mix == MIX_SHRINK) ? 15 : 30;
    shrink_pct = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 45 : 30;
    if (roll < grow_pct) begin
      act = roll[0] ? ACT_APPEND : ACT_INSERT;
    end else if (roll < grow_pct + shrink_pct) begin
      act = ACT_REMOVE;
    end else if (roll >= 98) begin
      act = ACT_NOP;
    end else begin
      case ($urandom_range(0, 3))
        0:       act = ACT_READ;
        1:       act = ACT_WRITE;
        2:       act = ACT_FIND_FIRST;
        default: act = ACT_FIND_LAST;
      endcase
    end
    send_request(act, pick_position(act == ACT_INSERT), pick_value());
  endtask

  // Corner cases: empty list, bounds, duplicates, full list, unused code
  task automatic directed_requests();
    send_request(ACT_READ, 5'd0, 32'h0);
    send_request(ACT_REMOVE, 5'd0, 32'h0);
    send_request(ACT_WRITE, 5'd0, 32'h1);
    send_request(ACT_FIND_FIRST, 5'd0, 32'h0);
    send_request(ACT_FIND_LAST, 5'd0, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 5'd1, 32'h1);
    send_request(ACT_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_request(ACT_APPEND, 5'd0, 32'h0);
    send_request(ACT_APPEND, 5'd0, 32'hAAAA_AAAA);
    send_request(ACT_INSERT, 5'd3, 32'h5555_5555);
    send_request(ACT_INSERT, 5'd1, 32'h0);
    send_request(ACT_READ, 5'd0, 32'h0);
    send_request(ACT_READ, 5'd4, 32'h0);
    send_request(ACT_READ, 5'd5, 32'h0);
    send_request(ACT_WRITE, 5'd4, 32'h1234_5678);
    send_request(ACT_FIND_FIRST, 5'd0, 32'h0);
    send_request(ACT_FIND_LAST, 5'd0, 32'h0);
    send_request(ACT_FIND_FIRST, 5'd0, 32'hDEAD_BEEF);
    send_request(ACT_REMOVE, 5'd5, 32'h0);
    send_request(ACT_REMOVE, 5'd4, 32'h0);
    send_request(ACT_REMOVE, 5'd0, 32'h0);
    send_request(ACT_NOP, 5'd31, 32'hFFFF_FFFF);
    while (sb.count < LIST_DEPTH) send_request(ACT_APPEND, 5'd0, $urandom);
    send_request(ACT_APPEND, 5'd0, 32'h7);
    send_request(ACT_INSERT, 5'd16, 32'h7);
    send_request(ACT_INSERT, 5'd3, 32'h7);
    send_request(ACT_READ, 5'd15, 32'h0);
    send_request(ACT_FIND_LAST, 5'd0, sb.entries[LIST_DEPTH-1]);
    send_request(ACT_WRITE, 5'd15, 32'h0);
    send_request(ACT_REMOVE, 5'd16, 32'h0);
    send_request(ACT_REMOVE, 5'd0, 32'h0);
    send_request(ACT_READ, 5'd16, 32'h0);
  endtask

  initial begin
    int n;
    sb           = new();
    stall_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    action       = ACT_APPEND;
    position     = '0;
    value        = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_requests();
    wait_for_results();

    // Random traffic in phases that push toward full, toward empty, or stay mixed
    for (n = 0; n < ITEM_COUNT; n++) begin
      if (n > 0 && n % (3 * PHASE_LEN) == 0) wait_for_results();
      random_request((n / PHASE_LEN) % 3);
      if (n < ITEM_COUNT - CALM_TAIL && $urandom_range(0, 5) == 0) begin
        idle_for($urandom_range(1, 12));
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
